// ===== hw/rtl/ansi_truecolor_stream_remap_defines.svh =====
// Assertion macros shared by the remapper's checker.
`ifndef ANSI_TRUECOLOR_STREAM_REMAP_DEFINES_SVH
`define ANSI_TRUECOLOR_STREAM_REMAP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ATSR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atsr assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ATSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atsr assertion failed");

`endif

// ===== hw/rtl/atsr_pkg.sv =====
// Shared types, constants and helper functions of the truecolor remapper.
package atsr_pkg;

    localparam int ATSR_MAP_DEPTH = 64;
    localparam int WIN_LEN        = 18;
    localparam int ESC_LEN        = 17;
    localparam int ESC_LAST       = 16;
    localparam int ENTRY_INDEX_W  = 6;
    localparam int FILL_W         = 5;
    localparam int ESC_CNT_W      = 5;
    localparam int COLOR_W        = 24;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;

    typedef logic [7:0] byte_t;

    // Key walking down the map chain, with the first hit found so far.
    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] key;
        logic               hit;
        logic [COLOR_W-1:0] to_color;
    } map_probe_t;

    // Per-position control of one window cell.
    typedef struct packed {
        logic load;
        logic shift;
        logic rewrite;
    } win_ctrl_t;

    function automatic logic is_digit(input byte_t b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic [9:0] value3(input byte_t b0, input byte_t b1, input byte_t b2);
        return 10'(b0[3:0]) * 10'd100 + 10'(b1[3:0]) * 10'd10 + 10'(b2[3:0]);
    endfunction

    // Three zero-padded ASCII digits, hundreds in the top byte.
    function automatic logic [23:0] dec3_ascii(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [16:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r    = 7'(v - 8'(h) * 8'd100);
        // r * 103 >> 10 equals r / 10 for r below 100
        prod = 17'(r) * 17'd103;
        t    = 4'(prod >> 10);
        o    = 4'(r - 7'(t) * 7'd10);
        return {4'h3, 2'b00, h, 4'h3, t, 4'h3, o};
    endfunction

endpackage

// ===== hw/rtl/atsr_win_cell.sv =====
// One byte cell of the sliding window chain.
module atsr_win_cell
    import atsr_pkg::*;
(
    input  logic      clk,
    input  win_ctrl_t ctrl,
    input  byte_t     load_byte,
    input  byte_t     shift_byte,
    input  byte_t     rewrite_byte,
    output byte_t     cell_byte
);

    byte_t byte_reg;
    byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = shift_byte;
        end
        else if (ctrl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctrl.rewrite)
        begin
            byte_next = rewrite_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

// ===== hw/rtl/atsr_map_cell.sv =====
// One color map slot; compares the passing key and forwards the first hit.
module atsr_map_cell
    import atsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               wr_valid,
    input  logic [COLOR_W-1:0] wr_from,
    input  logic [COLOR_W-1:0] wr_to,
    input  map_probe_t         probe_in,
    output map_probe_t         probe_out
);

    logic               slot_valid_reg;
    logic               slot_valid_next;
    logic [COLOR_W-1:0] from_reg;
    logic [COLOR_W-1:0] to_reg;
    logic               probe_valid_reg;
    logic [COLOR_W-1:0] probe_key_reg;
    logic               probe_hit_reg;
    logic               probe_hit_next;
    logic [COLOR_W-1:0] probe_to_reg;
    logic [COLOR_W-1:0] probe_to_next;

    assign slot_valid_next = wr_en ? wr_valid : slot_valid_reg;

    // an earlier slot's hit wins over this one
    assign probe_hit_next = probe_in.hit || (slot_valid_reg && (from_reg == probe_in.key));
    assign probe_to_next  = probe_in.hit ? probe_in.to_color : to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= 1'b0;
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg  <= slot_valid_next;
            probe_valid_reg <= probe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            from_reg <= wr_from;
            to_reg   <= wr_to;
        end
        probe_key_reg <= probe_in.key;
        probe_hit_reg <= probe_hit_next;
        probe_to_reg  <= probe_to_next;
    end

    assign probe_out.valid    = probe_valid_reg;
    assign probe_out.key      = probe_key_reg;
    assign probe_out.hit      = probe_hit_reg;
    assign probe_out.to_color = probe_to_reg;

endmodule

// ===== hw/rtl/ansi_truecolor_stream_remap.sv =====
// Truecolor escape remapper: bytes enter an 18-cell window chain and leave in input
// order. Each stream byte is accepted, then takes a window check before the next byte
// is taken. A window that holds "0(3|4)8;2;RRR;GGG;BBB" plus "m" or ";" with the
// remap enabled and every value at most 255 sends its color key down a chain of
// MAP_DEPTH map cells, one cell per cycle, before its 17 beats go out one per cycle
// while the result side keeps up. A byte marked last drains the window one beat per
// held byte. A map load leaves the input side ready in the idle state.
module ansi_truecolor_stream_remap
    import atsr_pkg::*;
#(
    parameter int MAP_DEPTH = ATSR_MAP_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic                     operation,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic [ENTRY_INDEX_W-1:0] entry_index,
    input  logic                     entry_valid,
    input  logic [7:0]               from_red,
    input  logic [7:0]               from_green,
    input  logic [7:0]               from_blue,
    input  logic [7:0]               to_red,
    input  logic [7:0]               to_green,
    input  logic [7:0]               to_blue,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [7:0]               out_byte,
    output logic                     last_out
);

    localparam int SLOT_W = ($clog2(MAP_DEPTH) > ENTRY_INDEX_W) ?
                            $clog2(MAP_DEPTH) : ENTRY_INDEX_W;
    localparam int POS_RED   = 6;
    localparam int POS_GREEN = 10;
    localparam int POS_BLUE  = 14;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_ESC   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic                 last_reg;
    logic                 last_next;
    logic [ESC_CNT_W-1:0] esc_cnt_reg;
    logic [ESC_CNT_W-1:0] esc_cnt_next;
    logic                 remap_enable_reg;
    logic                 remap_enable_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    byte_t                out_byte_reg;
    logic                 last_out_reg;

    logic                 can_emit;
    logic                 item_acc;
    logic                 data_acc;
    logic                 map_wr;
    logic                 emit;
    logic                 emit_last;
    logic                 shift_en;
    logic                 launch;
    logic                 rewrite_en;
    logic                 esc_match;
    logic                 colors_in_range;
    logic [9:0]           val_red;
    logic [9:0]           val_green;
    logic [9:0]           val_blue;
    logic [COLOR_W-1:0]   color_key;
    logic [23:0]          dec_red;
    logic [23:0]          dec_green;
    logic [23:0]          dec_blue;
    logic [SLOT_W-1:0]    slot_sel;

    byte_t      win_byte   [0:WIN_LEN-1];
    byte_t      shift_src  [0:WIN_LEN-1];
    byte_t      rw_byte    [0:WIN_LEN-1];
    logic       rw_pos     [0:WIN_LEN-1];
    win_ctrl_t  win_ctrl   [0:WIN_LEN-1];
    map_probe_t probe      [0:MAP_DEPTH];

    // ---------------- window chain ----------------
    genvar i;
    generate
        for (i = 0; i < WIN_LEN; i++)
        begin : g_win
            if (i == WIN_LEN - 1)
            begin : g_tail
                assign shift_src[i] = win_byte[i];
            end
            else
            begin : g_body
                assign shift_src[i] = win_byte[i+1];
            end

            assign win_ctrl[i].load    = data_acc && (fill_reg == FILL_W'(i));
            assign win_ctrl[i].shift   = shift_en;
            assign win_ctrl[i].rewrite = rewrite_en && rw_pos[i];

            atsr_win_cell u_cell (
                .clk          (clk),
                .ctrl         (win_ctrl[i]),
                .load_byte    (data_byte),
                .shift_byte   (shift_src[i]),
                .rewrite_byte (rw_byte[i]),
                .cell_byte    (win_byte[i])
            );
        end
    endgenerate

    // ---------------- escape detection and decode ----------------
    assign esc_match = (win_byte[0] == CH_0) &&
                       ((win_byte[1] == CH_3) || (win_byte[1] == CH_4)) &&
                       (win_byte[2] == CH_8) && (win_byte[3] == CH_SEMI) &&
                       (win_byte[4] == CH_2) && (win_byte[5] == CH_SEMI) &&
                       is_digit(win_byte[6]) && is_digit(win_byte[7]) &&
                       is_digit(win_byte[8]) && (win_byte[9] == CH_SEMI) &&
                       is_digit(win_byte[10]) && is_digit(win_byte[11]) &&
                       is_digit(win_byte[12]) && (win_byte[13] == CH_SEMI) &&
                       is_digit(win_byte[14]) && is_digit(win_byte[15]) &&
                       is_digit(win_byte[16]) &&
                       ((win_byte[17] == CH_M) || (win_byte[17] == CH_SEMI));

    assign val_red   = value3(win_byte[6], win_byte[7], win_byte[8]);
    assign val_green = value3(win_byte[10], win_byte[11], win_byte[12]);
    assign val_blue  = value3(win_byte[14], win_byte[15], win_byte[16]);

    assign colors_in_range = (val_red <= 10'd255) && (val_green <= 10'd255) &&
                             (val_blue <= 10'd255);
    assign color_key = {val_red[7:0], val_green[7:0], val_blue[7:0]};

    // ---------------- map chain ----------------
    assign slot_sel = SLOT_W'(entry_index);

    assign probe[0].valid    = launch;
    assign probe[0].key      = color_key;
    assign probe[0].hit      = 1'b0;
    assign probe[0].to_color = '0;

    genvar k;
    generate
        for (k = 0; k < MAP_DEPTH; k++)
        begin : g_map
            atsr_map_cell u_slot (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (map_wr && (slot_sel == SLOT_W'(k))),
                .wr_valid  (entry_valid),
                .wr_from   ({from_red, from_green, from_blue}),
                .wr_to     ({to_red, to_green, to_blue}),
                .probe_in  (probe[k]),
                .probe_out (probe[k+1])
            );
        end
    endgenerate

    // ---------------- rewrite digits ----------------
    assign dec_red   = dec3_ascii(probe[MAP_DEPTH].to_color[23:16]);
    assign dec_green = dec3_ascii(probe[MAP_DEPTH].to_color[15:8]);
    assign dec_blue  = dec3_ascii(probe[MAP_DEPTH].to_color[7:0]);

    always_comb
    begin
        for (int p = 0; p < WIN_LEN; p++)
        begin
            rw_byte[p] = win_byte[p];
            rw_pos[p]  = 1'b0;
        end
        for (int d = 0; d < 3; d++)
        begin
            rw_byte[POS_RED + d]   = dec_red[23 - 8*d -: 8];
            rw_byte[POS_GREEN + d] = dec_green[23 - 8*d -: 8];
            rw_byte[POS_BLUE + d]  = dec_blue[23 - 8*d -: 8];
            rw_pos[POS_RED + d]    = 1'b1;
            rw_pos[POS_GREEN + d]  = 1'b1;
            rw_pos[POS_BLUE + d]   = 1'b1;
        end
    end

    // ---------------- control ----------------
    assign can_emit   = !out_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign data_acc   = item_acc && !operation;
    assign map_wr     = item_acc && operation;

    assign remap_enable_next = cfg_we ? cfg_wdata : remap_enable_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        last_next    = last_reg;
        esc_cnt_next = esc_cnt_reg;
        emit         = 1'b0;
        emit_last    = 1'b0;
        shift_en     = 1'b0;
        launch       = 1'b0;
        rewrite_en   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (data_acc)
                begin
                    fill_next  = fill_reg + FILL_W'(1);
                    last_next  = last_byte;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (fill_reg == FILL_W'(WIN_LEN))
                begin
                    if (remap_enable_reg && esc_match)
                    begin
                        esc_cnt_next = '0;
                        if (colors_in_range)
                        begin
                            launch     = 1'b1;
                            state_next = S_LOOK;
                        end
                        else
                        begin
                            state_next = S_ESC;
                        end
                    end
                    else if (can_emit)
                    begin
                        emit       = 1'b1;
                        shift_en   = 1'b1;
                        fill_next  = FILL_W'(WIN_LEN - 1);
                        state_next = last_reg ? S_FLUSH : S_IDLE;
                    end
                end
                else
                begin
                    state_next = last_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (probe[MAP_DEPTH].valid)
                begin
                    rewrite_en = probe[MAP_DEPTH].hit;
                    state_next = S_ESC;
                end
            end
            S_ESC:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    shift_en = 1'b1;
                    if (esc_cnt_reg == ESC_CNT_W'(ESC_LAST))
                    begin
                        // terminator now sits in cell 0
                        fill_next  = FILL_W'(1);
                        state_next = last_reg ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        esc_cnt_next = esc_cnt_reg + ESC_CNT_W'(1);
                    end
                end
            end
            S_FLUSH:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    shift_en  = 1'b1;
                    emit_last = (fill_reg == FILL_W'(1));
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            last_reg         <= 1'b0;
            esc_cnt_reg      <= '0;
            remap_enable_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            last_reg         <= last_next;
            esc_cnt_reg      <= esc_cnt_next;
            remap_enable_reg <= remap_enable_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= win_byte[0];
            last_out_reg <= emit_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_out     = last_out_reg;

endmodule

// ===== hw/rtl/atsr_checker.sv =====
// Port-level checker for the truecolor remapper, bound to its top level.
`include "ansi_truecolor_stream_remap_defines.svh"

module atsr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       operation,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] out_byte,
    input logic       last_out
);

    // a stalled result beat holds
    `ATSR_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_byte) && $stable(last_out))

    // a map load completes in its own cycle
    `ATSR_ASSERT_NEXT(a_load_ready, item_valid && item_ready && operation, item_ready)

    // a stream beat always takes a window check before the next beat
    `ATSR_ASSERT_NEXT(a_data_busy, item_valid && item_ready && !operation, !item_ready)

    // the input side only closes because a stream beat was taken
    `ATSR_ASSERT_SAME(a_busy_cause, $fell(item_ready), $past(item_valid) && !$past(operation))

endmodule

bind ansi_truecolor_stream_remap atsr_checker u_atsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .last_out     (last_out)
);
